FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk; ASSERT_CLK is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/wmma_pkg.sv
// ----------------------------------------------------------------------------
// wmma_pkg
// Constants and types for the windowed min / max / mean block.
// ----------------------------------------------------------------------------
package wmma_pkg;

  localparam int WINDOW       = 128;   // power of two
  localparam int SAMPLE_WIDTH = 16;
  localparam int ADDR_W       = $clog2(WINDOW);
  localparam int SUM_W        = SAMPLE_WIDTH + ADDR_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic        [ADDR_W-1:0]       addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

endpackage

FILE: sv/wmma_ram.sv
// ----------------------------------------------------------------------------
// wmma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wmma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/windowed_min_max_avg.sv
// ----------------------------------------------------------------------------
// windowed_min_max_avg
// Sliding window minimum, maximum and floored mean of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_sample) takes one signed sample
//   per beat. The sample is written to a ring of WINDOW entries, then every
//   entry is read back, one RAM read per cycle, to form min, max and sum.
//   Output channel (out_valid / out_stall / out_window_*) returns one beat
//   per input beat. The mean is sum >>> log2(WINDOW), floored.
//   A sample passes through the SCAN, LAST and FINISH states before out_valid
//   rises; the scan length is set by the single read port of the sample RAM.
//   in_stall is low only in the idle state, so a new sample is not taken
//   until the previous one has been scanned and its result loaded.
//   The result sits in an output register, so a new sample is taken while
//   the previous result waits. If the receiver stalls longer than a scan,
//   the next scan holds in its final state until the output register frees.
//   Reset: write pointer to zero, store reads as all zero. Entries not yet
//   written are masked to zero by a fill marker, so no clearing pass runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_min_max_avg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wmma_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wmma_pkg::SAMPLE_WIDTH-1:0] out_window_min,
  output logic signed [wmma_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  output logic signed [wmma_pkg::SAMPLE_WIDTH-1:0] out_window_avg
);

  wmma_pkg::state_t  state_r, state_nxt;
  wmma_pkg::addr_t   wp_r, wp_nxt;
  logic              full_r, full_nxt;
  wmma_pkg::addr_t   cnt_r, cnt_nxt;

  // read pipeline tags, aligned with RAM read data
  logic              rd_vld_r, rd_first_r, rd_ok_r;

  wmma_pkg::sample_t lo_r, lo_nxt;
  wmma_pkg::sample_t hi_r, hi_nxt;
  wmma_pkg::sum_t    sum_r, sum_nxt;

  logic              out_valid_r, out_valid_nxt;
  wmma_pkg::sample_t out_min_r, out_max_r, out_avg_r;
  logic              load_out;

  logic              in_fire, out_fire, rd_en;
  wmma_pkg::sample_t rd_data, v;
  wmma_pkg::sum_t    avg_wide;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  wmma_ram #(
    .WIDTH (wmma_pkg::SAMPLE_WIDTH),
    .DEPTH (wmma_pkg::WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (wp_r),
    .wdata (in_sample),
    .re    (rd_en),
    .raddr (cnt_r),
    .rdata (rd_data)
  );

  // FSM: next state and outputs
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wp_nxt    = wp_r;
    full_nxt  = full_r;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    in_stall  = 1'b1;
    unique case (state_r)
      wmma_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          wp_nxt    = wp_r + 1'b1;
          if (wp_r == wmma_pkg::addr_t'(wmma_pkg::WINDOW - 1)) begin
            full_nxt = 1'b1;
          end
          cnt_nxt   = '0;
          state_nxt = wmma_pkg::ST_SCAN;
        end
      end
      wmma_pkg::ST_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == wmma_pkg::addr_t'(wmma_pkg::WINDOW - 1)) begin
          state_nxt = wmma_pkg::ST_LAST;
        end
      end
      wmma_pkg::ST_LAST: begin
        state_nxt = wmma_pkg::ST_FINISH;
      end
      wmma_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = wmma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmma_pkg::ST_IDLE;
      end
    endcase
  end

  // accumulate min / max / sum over the read stream
  always_comb begin
    v      = rd_ok_r ? rd_data : '0;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    sum_nxt = sum_r;
    if (rd_vld_r) begin
      if (rd_first_r) begin
        lo_nxt  = v;
        hi_nxt  = v;
        sum_nxt = wmma_pkg::sum_t'(v);
      end else begin
        if (v < lo_r) begin
          lo_nxt = v;
        end
        if (v > hi_r) begin
          hi_nxt = v;
        end
        sum_nxt = sum_r + wmma_pkg::sum_t'(v);
      end
    end
  end

  assign avg_wide = sum_r >>> wmma_pkg::ADDR_W;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmma_pkg::ST_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    // unwritten entries (past the fill mark before the first wrap) read as zero
    rd_first_r <= (cnt_r == '0);
    rd_ok_r    <= full_r || (cnt_r < wp_r);
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sum_r      <= sum_nxt;
    if (load_out) begin
      out_min_r <= lo_r;
      out_max_r <= hi_r;
      out_avg_r <= avg_wide[wmma_pkg::SAMPLE_WIDTH-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;
  assign out_window_max = out_max_r;
  assign out_window_avg = out_avg_r;

  `ASSERT_CLK(a_accept_starts_scan,
    in_fire |=> (state_r == wmma_pkg::ST_SCAN && cnt_r == '0),
    "accepted beat did not start a scan at entry zero")
  `ASSERT_CLK(a_read_from_scan,
    rd_vld_r |-> $past(state_r == wmma_pkg::ST_SCAN),
    "read data tagged valid outside a scan")
  `ASSERT_CLK(a_out_from_finish,
    $rose(out_valid_r) |-> $past(state_r == wmma_pkg::ST_FINISH),
    "result loaded outside finish state")
  `ASSERT_CLK(a_full_sticky, full_r |=> full_r, "fill marker dropped after wrap")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for windowed_min_max_avg: directed table, then random
// sample runs, with bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS   = 1875;
  localparam int WATCHDOG_LIMIT = 4000;  // scan + longest stall + longest gap, several times
  localparam int DRAIN_HOLD     = wmma_pkg::WINDOW + 3 + 16;
  localparam int N_DIR          = 18;
  localparam int MAX_PRINTS     = 200;

  typedef struct packed {
    wmma_pkg::sample_t lo;
    wmma_pkg::sample_t hi;
    wmma_pkg::sample_t mean;
  } window_stats_t;

  typedef struct packed {
    wmma_pkg::sample_t sample;
    logic              typed;
    wmma_pkg::sample_t lo;
    wmma_pkg::sample_t hi;
    wmma_pkg::sample_t mean;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  wmma_pkg::sample_t in_sample;
  logic              out_valid;
  logic              out_stall;
  wmma_pkg::sample_t out_window_min;
  wmma_pkg::sample_t out_window_max;
  wmma_pkg::sample_t out_window_avg;

  // shadow copy of the ring and its pointer
  wmma_pkg::sample_t ring_copy [wmma_pkg::WINDOW];
  int                ring_wp;
  window_stats_t     pending_stats [$];
  int                err_count;
  int                burst_left;

  // typed rows follow straight from an all-zero ring after reset
  dir_row_t dir_rows [N_DIR] = '{
    '{16'sh7FFF, 1'b1, 16'sd0,      16'sh7FFF, 16'sd255},
    '{16'sh8000, 1'b1, 16'sh8000,   16'sh7FFF, -16'sd1},
    '{16'sh0000, 1'b1, 16'sh8000,   16'sh7FFF, -16'sd1},
    '{16'shFFFF, 1'b0, '0, '0, '0},
    '{16'sh0001, 1'b0, '0, '0, '0},
    '{16'sh5555, 1'b0, '0, '0, '0},
    '{16'shAAAA, 1'b0, '0, '0, '0},
    '{16'sh00FF, 1'b0, '0, '0, '0},
    '{16'shFF00, 1'b0, '0, '0, '0},
    '{16'sh0100, 1'b0, '0, '0, '0},
    '{16'sh8001, 1'b0, '0, '0, '0},
    '{16'sh7FFE, 1'b0, '0, '0, '0},
    '{16'sh0080, 1'b0, '0, '0, '0},
    '{16'shFF80, 1'b0, '0, '0, '0},
    '{16'shFF7F, 1'b0, '0, '0, '0},
    '{16'sh8000, 1'b0, '0, '0, '0},
    '{16'sh8000, 1'b0, '0, '0, '0},
    '{16'sh7FFF, 1'b0, '0, '0, '0}
  };

  windowed_min_max_avg u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_min (out_window_min),
    .out_window_max (out_window_max),
    .out_window_avg (out_window_avg)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    // keep the log bounded on a badly broken design
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic window_stats_t push_and_scan(input wmma_pkg::sample_t s);
    window_stats_t r;
    longint        total;
    longint        q;
    ring_copy[ring_wp] = s;
    ring_wp = (ring_wp == wmma_pkg::WINDOW - 1) ? 0 : ring_wp + 1;
    r.lo  = ring_copy[0];
    r.hi  = ring_copy[0];
    total = 0;
    for (int i = 0; i < wmma_pkg::WINDOW; i++) begin
      total += ring_copy[i];
      if (ring_copy[i] < r.lo) r.lo = ring_copy[i];
      if (ring_copy[i] > r.hi) r.hi = ring_copy[i];
    end
    // floor division, rounds toward minus infinity
    q = total / wmma_pkg::WINDOW;
    if ((total % wmma_pkg::WINDOW) != 0 && total < 0) q = q - 1;
    r.mean = wmma_pkg::sample_t'(q);
    return r;
  endfunction

  // one input beat; a random gap of idle cycles, possibly none, opens at the start of each burst
  task automatic send_sample(input wmma_pkg::sample_t s, input logic typed,
                             input window_stats_t want);
    int            gap;
    window_stats_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(0, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = push_and_scan(s);
    pending_stats.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // receiver stall: segments of free flow, random, sparse and solid stall
  initial begin
    int mode;
    int len;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 300);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_stall <= ($urandom_range(0, 7) == 0);
          end
          default: begin
            out_stall <= 1'b1;
          end
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    window_stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: min %0d max %0d avg %0d",
                                  out_window_min, out_window_max, out_window_avg));
      end else begin
        want = pending_stats.pop_front();
        if (out_window_min !== want.lo)
          report_mismatch($sformatf("window_min got %0d expected %0d", out_window_min, want.lo));
        if (out_window_max !== want.hi)
          report_mismatch($sformatf("window_max got %0d expected %0d", out_window_max, want.hi));
        if (out_window_avg !== want.mean)
          report_mismatch($sformatf("window_avg got %0d expected %0d", out_window_avg, want.mean));
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int                kind;
    int                len;
    int                sent;
    int                v;
    int                step;
    wmma_pkg::sample_t run_val;
    err_count  = 0;
    burst_left = 0;
    ring_wp    = 0;
    for (int i = 0; i < wmma_pkg::WINDOW; i++) ring_copy[i] = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_sample(dir_rows[i].sample, dir_rows[i].typed,
                  '{dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].mean});
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 4);
      case (kind)
        0: begin
          len = $urandom_range(10, 80);
          for (int i = 0; i < len; i++)
            send_sample(wmma_pkg::sample_t'($urandom), 1'b0, '0);
        end
        1: begin
          // constant run at least as long as the window: once it fills the window, min, max and mean all equal it
          case ($urandom_range(0, 4))
            0:       run_val = 16'sh8000;
            1:       run_val = 16'sh7FFF;
            2:       run_val = 16'sh0000;
            3:       run_val = 16'shFFFF;
            default: run_val = wmma_pkg::sample_t'($urandom);
          endcase
          len = $urandom_range(wmma_pkg::WINDOW, wmma_pkg::WINDOW + 32);
          for (int i = 0; i < len; i++) send_sample(run_val, 1'b0, '0);
        end
        2: begin
          len = $urandom_range(20, 100);
          for (int i = 0; i < len; i++) begin
            v = $urandom_range(0, 31);
            send_sample(wmma_pkg::sample_t'(v - 16), 1'b0, '0);
          end
        end
        3: begin
          len = $urandom_range(wmma_pkg::WINDOW, wmma_pkg::WINDOW + 12);
          for (int i = 0; i < len; i++)
            send_sample(i[0] ? 16'sh7FFF : 16'sh8000, 1'b0, '0);
        end
        default: begin
          len  = $urandom_range(20, 120);
          v    = $urandom_range(0, 65535);
          step = $urandom_range(0, 600) - 300;
          for (int i = 0; i < len; i++) begin
            send_sample(wmma_pkg::sample_t'(v), 1'b0, '0);
            v = v + step;
          end
        end
      endcase
      sent += len;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_HOLD) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
